// File: src/assert_macros.svh
// Assertion macros used by the checker file of the chain block.
// Depends on nothing; a user provides clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define TKC_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is low
`define TKC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/tkc_pkg.sv
// Types and constants of the two-key chain block.
// Used by the cell and the top level; depends on nothing.
package tkc_pkg;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned ID_W    = 10;
  localparam int unsigned IDX_W   = 7;   // index or length, holds up to 127
  localparam int unsigned POS_W   = 6;   // position in a store of up to 64

  localparam logic [IDX_W-1:0] NO_PRED = 7'h7F;

  // Store write broadcast to all cells
  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] weight;
    logic [KEY_W-1:0] iq;
    logic [ID_W-1:0]  ident;
  } wr_t;

  // Search token, moves toward higher cell indexes
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] target;
    logic [KEY_W-1:0] weight;
    logic [KEY_W-1:0] iq;
    logic [IDX_W-1:0] len;
    logic [IDX_W-1:0] pred;
  } fwd_tok_t;

  // Backtrace token, moves toward lower cell indexes
  typedef struct packed {
    logic             valid;
    logic [IDX_W-1:0] wanted;
  } back_tok_t;

  // Per-cell report to the controller
  typedef struct packed {
    logic             done;
    logic [IDX_W-1:0] len;
    logic             push;
    logic [ID_W-1:0]  ident;
  } cell_rpt_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_BACK,
    ST_EMIT_RD,
    ST_EMIT_HOLD
  } state_t;

endpackage

// File: src/tkc_in_if.sv
// Input item channel: valid/ready handshake with the item fields.
// Depends on nothing.
interface tkc_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] weight;
  logic [15:0] iq;
  logic [9:0]  ident;
  logic        last_item;

  modport source (output valid, weight, iq, ident, last_item, input ready);
  modport sink   (input valid, weight, iq, ident, last_item, output ready);
endinterface

// File: src/tkc_out_if.sv
// Result channel: valid/ready handshake with one chain member per transfer.
// Depends on nothing.
interface tkc_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] chain_length;
  logic [9:0] member_ident;
  logic       last_of_run;

  modport source (output valid, chain_length, member_ident, last_of_run, input ready);
  modport sink   (input valid, chain_length, member_ident, last_of_run, output ready);
endinterface

// File: src/tkc_cell.sv
// One cell of the chain: holds one stored item with its chain length and
// predecessor, updates passing search and backtrace tokens. Uses tkc_pkg.
module tkc_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [tkc_pkg::IDX_W-1:0]      cell_idx,
  input  tkc_pkg::wr_t                   wr,
  input  tkc_pkg::fwd_tok_t              fwd_in,
  output tkc_pkg::fwd_tok_t              fwd_out,
  input  tkc_pkg::back_tok_t             back_in,
  output tkc_pkg::back_tok_t             back_out,
  output tkc_pkg::cell_rpt_t             rpt
);
  import tkc_pkg::*;

  logic [KEY_W-1:0] weight_r;
  logic [KEY_W-1:0] iq_r;
  logic [ID_W-1:0]  ident_r;
  logic [IDX_W-1:0] len_r;
  logic [IDX_W-1:0] pred_r;

  fwd_tok_t  fwd_nxt;
  back_tok_t back_nxt;
  fwd_tok_t  fwd_r;
  back_tok_t back_r;
  logic      is_target;
  logic      is_wanted;

  assign is_target = fwd_in.valid && (fwd_in.target == cell_idx);
  assign is_wanted = back_in.valid && (back_in.wanted == cell_idx);

  // Update the passing tokens against this cell's item
  always_comb begin
    fwd_nxt  = fwd_in;
    back_nxt = back_in;
    rpt      = '0;
    if (is_target) begin
      rpt.done      = 1'b1;
      rpt.len       = fwd_in.len;
      fwd_nxt.valid = 1'b0;
    end else if (fwd_in.valid) begin
      if ((fwd_in.weight > weight_r) && (fwd_in.iq < iq_r) &&
          (fwd_in.len < len_r + IDX_W'(1))) begin
        fwd_nxt.len  = len_r + IDX_W'(1);
        fwd_nxt.pred = cell_idx;
      end
    end
    if (is_wanted) begin
      rpt.push        = 1'b1;
      rpt.ident       = ident_r;
      back_nxt.wanted = pred_r;
    end
  end

  // Store the item and, when the search ends here, its result
  always_ff @(posedge clk) begin
    if (wr.en && (wr.idx == cell_idx)) begin
      weight_r <= wr.weight;
      iq_r     <= wr.iq;
      ident_r  <= wr.ident;
    end
    if (is_target) begin
      len_r  <= fwd_in.len;
      pred_r <= fwd_in.pred;
    end
  end

  // Advance the tokens to the neighbors
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r  <= '0;
      back_r <= '0;
    end else begin
      fwd_r  <= fwd_nxt;
      back_r <= back_nxt;
    end
  end

  assign fwd_out  = fwd_r;
  assign back_out = back_r;

endmodule

// File: src/two_key_longest_chain_dp.sv
// Longest two-key chain finder.
// Items arrive on in_chan, sorted by weight then iq; each transfer carries
// weight, iq, ident and last_item. Item n (counting from 0) is stored in
// cell n and a search token walks cells 0..n, one cell per cycle, so in_chan
// is not ready again until the token has reached cell n. Items beyond
// MAX_ITEMS are dropped.
// On the item flagged last_item a backtrace token walks all MAX_ITEMS cells
// from the top down, collecting the chain members into a stack memory. The
// chain is then sent on out_chan first member to last, each member read and
// held until taken before the next; chain_length repeats on every member
// and last_of_run marks the final one. in_chan stays not ready from the
// last item until the final member has transferred.
// A stall on out_chan holds the output register and the emit counter; no
// work is lost. Reset clears the item count, best chain and all tokens;
// stored items are not cleared and need no clearing pass.
module two_key_longest_chain_dp #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic      clk,
  input  logic      rst_n,
  tkc_in_if.sink    in_chan,
  tkc_out_if.source out_chan
);
  import tkc_pkg::*;

  state_t state_r, state_nxt;

  logic [IDX_W-1:0] count_r;
  logic [IDX_W-1:0] best_len_r;
  logic [POS_W-1:0] best_end_r;
  logic             last_pend_r;
  logic [IDX_W-1:0] depth_r;
  logic [IDX_W-1:0] emit_k_r;
  fwd_tok_t         fwd_inj_r;
  back_tok_t        back_inj_r;

  logic             out_valid_r;
  logic [IDX_W-1:0] out_len_r;
  logic [ID_W-1:0]  out_ident_r;
  logic             out_last_r;

  logic [ID_W-1:0]  trace_stack [MAX_ITEMS];

  wr_t              wr;
  fwd_tok_t         fwd_chain  [MAX_ITEMS];
  back_tok_t        back_chain [MAX_ITEMS];
  back_tok_t        back_tail;
  cell_rpt_t        rpts       [MAX_ITEMS];
  cell_rpt_t        rpt_any;

  logic             accept;
  logic             store_ok;
  logic             better;
  logic [IDX_W-1:0] best_len_nxt;
  logic [POS_W-1:0] best_end_nxt;
  logic [IDX_W-1:0] rd_addr;
  logic             out_take;

  assign in_chan.ready  = (state_r == ST_IDLE);
  assign accept         = in_chan.valid && in_chan.ready;
  assign store_ok       = count_r < IDX_W'(MAX_ITEMS);
  assign out_take       = out_valid_r && out_chan.ready;

  assign out_chan.valid        = out_valid_r;
  assign out_chan.chain_length = out_len_r;
  assign out_chan.member_ident = out_ident_r;
  assign out_chan.last_of_run  = out_last_r;

  // Broadcast the accepted item to the cells
  always_comb begin
    wr.en     = accept && store_ok;
    wr.idx    = count_r;
    wr.weight = in_chan.weight;
    wr.iq     = in_chan.iq;
    wr.ident  = in_chan.ident;
  end

  // Row of cells; search runs upward, backtrace runs downward
  assign fwd_chain[0]              = fwd_inj_r;
  assign back_chain[MAX_ITEMS-1]   = back_inj_r;

  for (genvar j = 0; j < MAX_ITEMS; j++) begin : g_cell
    if (j == MAX_ITEMS - 1) begin : g_top
      tkc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (IDX_W'(j)),
        .wr       (wr),
        .fwd_in   (fwd_chain[j]),
        .fwd_out  (),
        .back_in  (back_chain[j]),
        .back_out (back_chain[j-1]),
        .rpt      (rpts[j])
      );
    end else if (j == 0) begin : g_bottom
      tkc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (IDX_W'(j)),
        .wr       (wr),
        .fwd_in   (fwd_chain[j]),
        .fwd_out  (fwd_chain[j+1]),
        .back_in  (back_chain[j]),
        .back_out (back_tail),
        .rpt      (rpts[j])
      );
    end else begin : g_mid
      tkc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .cell_idx (IDX_W'(j)),
        .wr       (wr),
        .fwd_in   (fwd_chain[j]),
        .fwd_out  (fwd_chain[j+1]),
        .back_in  (back_chain[j]),
        .back_out (back_chain[j-1]),
        .rpt      (rpts[j])
      );
    end
  end

  // Merge cell reports; at most one cell reports in a cycle
  always_comb begin
    rpt_any = '0;
    for (int unsigned j = 0; j < MAX_ITEMS; j++) begin
      rpt_any = rpt_any | rpts[j];
    end
  end

  // Keep the earliest end among equal lengths
  always_comb begin
    better       = rpt_any.done && (rpt_any.len > best_len_r);
    best_len_nxt = better ? rpt_any.len : best_len_r;
    best_end_nxt = better ? count_r[POS_W-1:0] : best_end_r;
  end

  assign rd_addr = best_len_r - IDX_W'(1) - emit_k_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (store_ok) begin
            state_nxt = ST_SEARCH;
          end else if (in_chan.last_item) begin
            state_nxt = ST_BACK;
          end
        end
      end
      ST_SEARCH: begin
        if (rpt_any.done) begin
          state_nxt = last_pend_r ? ST_BACK : ST_IDLE;
        end
      end
      ST_BACK: begin
        if (back_tail.valid) begin
          state_nxt = ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (out_take) begin
          state_nxt = out_last_r ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Control registers: count, best chain, tokens, counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      best_len_r  <= '0;
      best_end_r  <= '0;
      last_pend_r <= 1'b0;
      depth_r     <= '0;
      emit_k_r    <= '0;
      fwd_inj_r   <= '0;
      back_inj_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fwd_inj_r.valid  <= 1'b0;
      back_inj_r.valid <= 1'b0;
      if (accept) begin
        last_pend_r <= in_chan.last_item;
        if (store_ok) begin
          fwd_inj_r.valid  <= 1'b1;
          fwd_inj_r.target <= count_r;
          fwd_inj_r.weight <= in_chan.weight;
          fwd_inj_r.iq     <= in_chan.iq;
          fwd_inj_r.len    <= IDX_W'(1);
          fwd_inj_r.pred   <= NO_PRED;
        end
      end
      if (state_r == ST_SEARCH && rpt_any.done) begin
        count_r    <= count_r + IDX_W'(1);
        best_len_r <= best_len_nxt;
        best_end_r <= best_end_nxt;
      end
      // Start the backtrace from the best end
      if (state_r != ST_BACK && state_nxt == ST_BACK) begin
        back_inj_r.valid  <= 1'b1;
        back_inj_r.wanted <= IDX_W'(best_end_nxt);
        depth_r           <= '0;
      end
      if (rpt_any.push) begin
        depth_r <= depth_r + IDX_W'(1);
      end
      if (state_r == ST_EMIT_RD) begin
        out_valid_r <= 1'b1;
      end
      if (state_r == ST_EMIT_HOLD && out_take) begin
        out_valid_r <= 1'b0;
        if (out_last_r) begin
          count_r     <= '0;
          best_len_r  <= '0;
          best_end_r  <= '0;
          last_pend_r <= 1'b0;
          emit_k_r    <= '0;
        end else begin
          emit_k_r <= emit_k_r + IDX_W'(1);
        end
      end
    end
  end

  // Trace stack: push in backtrace order, read in chain order
  always_ff @(posedge clk) begin
    if (rpt_any.push) begin
      trace_stack[depth_r[POS_W-1:0]] <= rpt_any.ident;
    end
    if (state_r == ST_EMIT_RD) begin
      out_ident_r <= trace_stack[rd_addr[POS_W-1:0]];
      out_len_r   <= best_len_r;
      out_last_r  <= (emit_k_r == best_len_r - IDX_W'(1));
    end
  end

endmodule

// File: src/tkc_checker.sv
// Port-level checker for the two-key chain block, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module tkc_checker #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] chain_length,
  input logic [9:0] member_ident,
  input logic       last_of_run
);

  // A stalled result holds its payload
  `TKC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
                   out_valid && $stable(chain_length) && $stable(member_ident) && $stable(last_of_run))

  // Chain length is within the store size
  `TKC_ASSERT_IMPL(a_len_range, out_valid,
                   chain_length != 7'd0 && chain_length <= 7'(MAX_ITEMS))

  // No input is taken while a chain is being sent
  `TKC_ASSERT_IMPL(a_no_overlap, out_valid, !in_ready)

  // After a member that is not the last, the run goes on
  `TKC_ASSERT_NEXT(a_run_continues, out_valid && out_ready && !last_of_run,
                   !in_ready && !(in_valid && in_ready))

endmodule

bind two_key_longest_chain_dp tkc_checker #(.MAX_ITEMS(MAX_ITEMS)) u_tkc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_chan.valid),
  .in_ready     (in_chan.ready),
  .out_valid    (out_chan.valid),
  .out_ready    (out_chan.ready),
  .chain_length (out_chan.chain_length),
  .member_ident (out_chan.member_ident),
  .last_of_run  (out_chan.last_of_run)
);
